[rtl/capacitive_touch_sense_core_defines.svh]
// Assertion macros used by the checker file of the capacitive touch sense core.
// Depends on nothing; each macro expects clk and rst_n in the scope where it is used.
`ifndef CAPACITIVE_TOUCH_SENSE_CORE_DEFINES_SVH
`define CAPACITIVE_TOUCH_SENSE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTSC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CTSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ctsc_pkg.sv]
// Shared types and constants of the capacitive touch sense core.
// Used by the core and its checker; depends on nothing.
package ctsc_pkg;

    localparam int SAMPLE_W   = 8;
    localparam int TOTAL_W    = 20;
    localparam int PERIOD_W   = 16;
    localparam int BASE_W     = 28;
    localparam int MS_W       = 17;
    localparam int REG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [SAMPLE_W-1:0] SAMPLES_RESET = 8'd30;
    localparam logic [TOTAL_W-1:0]  TIMEOUT_RESET = 20'd620000;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 16'd20000;
    localparam logic [BASE_W-1:0]   BASE_MAX      = 28'hFFFFFFF;
    localparam logic [MS_W-1:0]     MS_MAX        = 17'h1FFFF;
    localparam logic [TOTAL_W-1:0]  TOTAL_MAX     = 20'hFFFFF;

    localparam logic [REG_IDX_W-1:0] REG_SAMPLES = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD  = 2'd2;

    localparam logic [1:0] RX_RELEASED   = 2'd0;
    localparam logic [1:0] RX_DRIVE_LOW  = 2'd1;
    localparam logic [1:0] RX_DRIVE_HIGH = 2'd2;

    typedef struct packed {
        logic start_req;
        logic rx_level;
        logic ms_strobe;
        logic clear_baseline;
    } tick_t;

    typedef struct packed {
        logic               send_level;
        logic [1:0]         rx_drive;
        logic               busy_res;
        logic               done_res;
        logic               status;
        logic [TOTAL_W-1:0] sensed_value;
    } result_t;

    typedef struct packed {
        logic [REG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] wr_data;
    } cfg_t;

endpackage

[rtl/ctsc_chan_if.sv]
// Valid/ready channel interface carrying one payload per transfer.
// The payload type is set per instance, normally from ctsc_pkg.
interface ctsc_chan_if #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/capacitive_touch_sense_core.sv]
// Capacitive touch sense core: charge-time measurement with baseline auto-calibration.
// Depends on ctsc_pkg and the ctsc_chan_if channel interface.
//
// Each transfer on tick_ch is one sensor tick, and each one yields exactly one transfer on
// result_ch. The core takes a tick in every cycle unless result_ch is stalled; a tick passes
// through the input register and its result through the result register before the result
// can transfer on result_ch. The rate is set by the measurement state update, which the core
// applies once for each tick as the tick leaves the input register.
// The baseline test uses the exact form 10 * (diff + 1) <= baseline, so no divider is needed.
// Configuration writes on cfg_ch are always accepted and take effect at once.
module capacitive_touch_sense_core (
    input logic         clk,
    input logic         rst_n,
    ctsc_chan_if.sink   tick_ch,
    ctsc_chan_if.source result_ch,
    ctsc_chan_if.sink   cfg_ch
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PRE,
        PH_CHARGE,
        PH_PULSE,
        PH_DISCH
    } phase_t;

    logic [ctsc_pkg::SAMPLE_W-1:0] samples_reg;
    logic [ctsc_pkg::TOTAL_W-1:0]  timeout_reg;
    logic [ctsc_pkg::PERIOD_W-1:0] period_reg;

    logic            in_valid_reg;
    ctsc_pkg::tick_t in_data_reg;
    logic            res_valid_reg;
    logic            res_valid_next;
    ctsc_pkg::result_t res_data_reg;
    ctsc_pkg::result_t res_data_next;

    phase_t                        phase_reg;
    phase_t                        phase_next;
    logic [ctsc_pkg::SAMPLE_W-1:0] count_reg;
    logic [ctsc_pkg::SAMPLE_W-1:0] count_next;
    logic [ctsc_pkg::TOTAL_W-1:0]  total_reg;
    logic [ctsc_pkg::TOTAL_W-1:0]  total_next;
    logic [ctsc_pkg::BASE_W-1:0]   base_reg;
    logic [ctsc_pkg::BASE_W-1:0]   base_next;
    logic [ctsc_pkg::MS_W-1:0]     ms_reg;

    logic advance;
    logic process;
    logic in_ready;

    logic [ctsc_pkg::MS_W-1:0]     ms_inc;
    logic [ctsc_pkg::BASE_W-1:0]   base_clr;
    logic                          counting;
    logic [ctsc_pkg::TOTAL_W-1:0]  count_total;
    logic                          timed_out;
    logic [ctsc_pkg::SAMPLE_W-1:0] sample_inc;
    logic [ctsc_pkg::TOTAL_W-1:0]  fin_total;
    logic [ctsc_pkg::BASE_W-1:0]   fin_total_ext;
    logic [ctsc_pkg::BASE_W-1:0]   diff;
    logic [31:0]                   diff_scaled;
    logic                          recal;
    logic [ctsc_pkg::BASE_W-1:0]   fin_base;
    logic [ctsc_pkg::MS_W-1:0]     fin_ms;
    logic [ctsc_pkg::TOTAL_W-1:0]  fin_sensed;
    logic                          finish_ok;
    logic                          finish_to;

    assign advance         = !res_valid_reg || result_ch.ready;
    assign process         = in_valid_reg && advance;
    assign in_ready        = !in_valid_reg || advance;
    assign tick_ch.ready   = in_ready;
    assign cfg_ch.ready    = 1'b1;
    assign result_ch.valid = res_valid_reg;
    assign result_ch.data  = res_data_reg;

    always_comb
    begin
        ms_inc = ms_reg;
        if (in_data_reg.ms_strobe && (ms_reg != ctsc_pkg::MS_MAX))
        begin
            ms_inc = ms_reg + 1'b1;
        end
        base_clr = in_data_reg.clear_baseline ? ctsc_pkg::BASE_MAX : base_reg;

        counting = (phase_reg == PH_CHARGE) ? !in_data_reg.rx_level : in_data_reg.rx_level;
        count_total = total_reg;
        if (counting && (total_reg != ctsc_pkg::TOTAL_MAX))
        begin
            count_total = total_reg + 1'b1;
        end
        timed_out  = (count_total >= timeout_reg);
        sample_inc = count_reg + 1'b1;

        fin_total     = (phase_reg == PH_IDLE) ? '0 : total_reg;
        fin_total_ext = {{(ctsc_pkg::BASE_W - ctsc_pkg::TOTAL_W){1'b0}}, fin_total};
        diff = (fin_total_ext > base_clr) ? (fin_total_ext - base_clr)
                                          : (base_clr - fin_total_ext);
        diff_scaled = ({4'b0000, diff} << 3) + ({4'b0000, diff} << 1) + 32'd10;
        recal = (ms_reg > {1'b0, period_reg}) && (diff_scaled <= {4'b0000, base_clr});
        if (recal || (fin_total_ext < base_clr))
        begin
            fin_base = fin_total_ext;
        end
        else
        begin
            fin_base = base_clr;
        end
        fin_ms = recal ? '0 : ms_inc;
        if (!recal && (fin_total_ext >= base_clr))
        begin
            fin_sensed = fin_total - base_clr[ctsc_pkg::TOTAL_W-1:0];
        end
        else
        begin
            fin_sensed = '0;
        end

        phase_next = phase_reg;
        count_next = count_reg;
        total_next = total_reg;
        finish_ok  = 1'b0;
        finish_to  = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (in_data_reg.start_req)
                begin
                    count_next = '0;
                    total_next = '0;
                    if (samples_reg == '0)
                    begin
                        finish_ok = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_PRE;
                    end
                end
            end
            PH_PRE:
            begin
                phase_next = PH_CHARGE;
            end
            PH_CHARGE:
            begin
                total_next = count_total;
                if (timed_out)
                begin
                    phase_next = PH_IDLE;
                    finish_to  = 1'b1;
                end
                else if (in_data_reg.rx_level)
                begin
                    phase_next = PH_PULSE;
                end
            end
            PH_PULSE:
            begin
                phase_next = PH_DISCH;
            end
            PH_DISCH:
            begin
                total_next = count_total;
                if (timed_out)
                begin
                    phase_next = PH_IDLE;
                    finish_to  = 1'b1;
                end
                else if (!in_data_reg.rx_level)
                begin
                    count_next = sample_inc;
                    if ((sample_inc >= samples_reg) || (sample_inc == '0))
                    begin
                        phase_next = PH_IDLE;
                        finish_ok  = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_PRE;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        base_next = finish_ok ? fin_base : base_clr;

        res_data_next.send_level = (phase_next == PH_CHARGE) || (phase_next == PH_PULSE);
        case (phase_next)
            PH_PRE:   res_data_next.rx_drive = ctsc_pkg::RX_DRIVE_LOW;
            PH_PULSE: res_data_next.rx_drive = ctsc_pkg::RX_DRIVE_HIGH;
            default:  res_data_next.rx_drive = ctsc_pkg::RX_RELEASED;
        endcase
        res_data_next.busy_res     = (phase_next != PH_IDLE);
        res_data_next.done_res     = finish_ok || finish_to;
        res_data_next.status       = finish_to;
        res_data_next.sensed_value = finish_ok ? fin_sensed : '0;

        res_valid_next = advance ? in_valid_reg : res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_reg   <= ctsc_pkg::SAMPLES_RESET;
            timeout_reg   <= ctsc_pkg::TIMEOUT_RESET;
            period_reg    <= ctsc_pkg::PERIOD_RESET;
            in_valid_reg  <= 1'b0;
            in_data_reg   <= '0;
            res_valid_reg <= 1'b0;
            res_data_reg  <= '0;
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            base_reg      <= ctsc_pkg::BASE_MAX;
            ms_reg        <= '0;
        end
        else
        begin
            if (cfg_ch.valid)
            begin
                case (cfg_ch.data.reg_index)
                    ctsc_pkg::REG_SAMPLES:
                        samples_reg <= cfg_ch.data.wr_data[ctsc_pkg::SAMPLE_W-1:0];
                    ctsc_pkg::REG_TIMEOUT:
                        timeout_reg <= cfg_ch.data.wr_data[ctsc_pkg::TOTAL_W-1:0];
                    ctsc_pkg::REG_PERIOD:
                        period_reg <= cfg_ch.data.wr_data[ctsc_pkg::PERIOD_W-1:0];
                    default:
                        samples_reg <= samples_reg;
                endcase
            end
            if (in_ready)
            begin
                in_valid_reg <= tick_ch.valid;
                in_data_reg  <= tick_ch.data;
            end
            res_valid_reg <= res_valid_next;
            if (process)
            begin
                res_data_reg <= res_data_next;
                phase_reg    <= phase_next;
                count_reg    <= count_next;
                total_reg    <= total_next;
                base_reg     <= base_next;
                ms_reg       <= finish_ok ? fin_ms : ms_inc;
            end
        end
    end

endmodule

[rtl/ctsc_checker.sv]
// Port-level checker for the capacitive touch sense core, attached by bind.
// Depends on ctsc_pkg and the assertion macros in capacitive_touch_sense_core_defines.svh.
`include "capacitive_touch_sense_core_defines.svh"

module ctsc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              res_valid,
    input logic              res_ready,
    input ctsc_pkg::result_t res_data
);

    `CTSC_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_data), "result changed while stalled")
    `CTSC_ASSERT_SAME(a_done_idle, res_valid && res_data.done_res, !res_data.busy_res, "busy on the finishing tick")
    `CTSC_ASSERT_SAME(a_status_done, res_valid && res_data.status, res_data.done_res, "timeout status without done")
    `CTSC_ASSERT_SAME(a_sensed_ok, res_valid && (res_data.sensed_value != '0), res_data.done_res && !res_data.status, "sensed value outside a good finish")
    `CTSC_ASSERT_SAME(a_pre_send_low, res_valid && (res_data.rx_drive == ctsc_pkg::RX_DRIVE_LOW), !res_data.send_level && res_data.busy_res, "send high while receive is driven low")

endmodule

bind capacitive_touch_sense_core ctsc_checker u_ctsc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result_ch.valid),
    .res_ready (result_ch.ready),
    .res_data  (result_ch.data)
);
